@@ hdl/gcwd_pkg.sv @@
package gcwd_pkg;

  localparam int WORD_W  = 32;
  localparam int OP_W    = 6;
  localparam int IDX_W   = 6;
  localparam int OP_LSB  = 24;
  localparam int MAX_LEN = (32 + 64 + 64 + 16) / 4;

  localparam logic [OP_W-1:0] OP_MASK = 6'h3f;

  // triangle variants
  localparam logic [OP_W-1:0] OP_TRI           = 6'h08;
  localparam logic [OP_W-1:0] OP_TRI_Z         = 6'h09;
  localparam logic [OP_W-1:0] OP_TRI_TEX       = 6'h0a;
  localparam logic [OP_W-1:0] OP_TRI_TEX_Z     = 6'h0b;
  localparam logic [OP_W-1:0] OP_TRI_SHADE     = 6'h0c;
  localparam logic [OP_W-1:0] OP_TRI_SHADE_Z   = 6'h0d;
  localparam logic [OP_W-1:0] OP_TRI_SHADE_TEX = 6'h0e;
  localparam logic [OP_W-1:0] OP_TRI_SHADE_TXZ = 6'h0f;
  // texture rectangles
  localparam logic [OP_W-1:0] OP_TEX_RECT      = 6'h24;
  localparam logic [OP_W-1:0] OP_TEX_RECT_FLIP = 6'h25;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_READ,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic wr;   // store incoming word
    logic rd;   // read stored word at drain index
    logic adv;  // step drain index
    logic clr;  // command finished
  } cmd_t;

  typedef struct packed {
    logic fill_done;
    logic last;
  } status_t;

  function automatic logic [IDX_W-1:0] cmd_len(input logic [OP_W-1:0] op);
    logic [IDX_W-1:0] len;
    case (op)
      OP_TRI:           len = IDX_W'(32 / 4);
      OP_TRI_Z:         len = IDX_W'((32 + 16) / 4);
      OP_TRI_TEX:       len = IDX_W'((32 + 64) / 4);
      OP_TRI_TEX_Z:     len = IDX_W'((32 + 64 + 16) / 4);
      OP_TRI_SHADE:     len = IDX_W'((32 + 64) / 4);
      OP_TRI_SHADE_Z:   len = IDX_W'((32 + 64 + 16) / 4);
      OP_TRI_SHADE_TEX: len = IDX_W'((32 + 64 + 64) / 4);
      OP_TRI_SHADE_TXZ: len = IDX_W'((32 + 64 + 64 + 16) / 4);
      OP_TEX_RECT:      len = IDX_W'(4);
      OP_TEX_RECT_FLIP: len = IDX_W'(4);
      default:          len = IDX_W'(2);
    endcase
    return len;
  endfunction

endpackage

@@ hdl/gcwd_if.sv @@
interface gcwd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] cmd_word;

  modport source (output valid, output cmd_word, input ready);
  modport sink (input valid, input cmd_word, output ready);
endinterface

interface gcwd_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  opcode;
  logic [5:0]  word_index;
  logic [31:0] data_word;
  logic        last_word;

  modport source (output valid, output opcode, output word_index, output data_word,
                  output last_word, input ready);
  modport sink (input valid, input opcode, input word_index, input data_word,
                input last_word, output ready);
endinterface

@@ hdl/gcwd_ram.sv @@
module gcwd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/gcwd_ctrl.sv @@
module gcwd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  gcwd_pkg::status_t st,
  output gcwd_pkg::cmd_t    cmd
);
  import gcwd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_FILL: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr = 1'b1;
          if (st.fill_done) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (st.last) begin
            cmd.clr   = 1'b1;
            state_nxt = ST_FILL;
          end else begin
            cmd.adv   = 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_SEND))
    else $error("read not followed by send");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.clr && state_r == ST_SEND) |=> (state_r == ST_FILL && in_ready))
    else $error("no return to fill after last word");

  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input open while a word is offered");

endmodule

@@ hdl/gcwd_dpath.sv @@
module gcwd_dpath #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gcwd_pkg::cmd_t                cmd,
  output gcwd_pkg::status_t             st,
  input  logic [gcwd_pkg::WORD_W-1:0]   in_word,
  output logic [gcwd_pkg::OP_W-1:0]     opcode,
  output logic [gcwd_pkg::IDX_W-1:0]    word_index,
  output logic [gcwd_pkg::WORD_W-1:0]   data_word,
  output logic                          last_word
);
  import gcwd_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  logic [IDX_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] len_r;
  logic [OP_W-1:0]  op_r;
  logic [OP_W-1:0]  in_op;
  logic [IDX_W-1:0] len_cur;

  assign in_op   = in_word[OP_LSB +: OP_W] & OP_MASK;
  // the first word of a command sets its length
  assign len_cur = (count_r == '0) ? cmd_len(in_op) : len_r;

  assign st.fill_done = ({1'b0, count_r} + (IDX_W+1)'(1)) >= {1'b0, len_cur};
  assign st.last      = ({1'b0, idx_r} + (IDX_W+1)'(1)) == {1'b0, len_r};

  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    if (cmd.wr) begin
      count_nxt = count_r + IDX_W'(1);
    end
    if (cmd.adv) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    if (cmd.clr) begin
      count_nxt = '0;
      idx_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && count_r == '0) begin
      op_r  <= in_op;
      len_r <= len_cur;
    end
  end

  gcwd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (AW'(count_r)),
    .wdata (in_word),
    .re    (cmd.rd),
    .raddr (AW'(idx_r)),
    .rdata (data_word)
  );

  assign opcode     = op_r;
  assign word_index = idx_r;
  assign last_word  = st.last;

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= IDX_W'(MAX_LEN))
    else $error("pending count beyond longest command");

  assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> (idx_r < len_r && count_r == len_r))
    else $error("drain index outside held command");

  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr, cmd.rd, cmd.adv || cmd.clr}))
    else $error("fill and drain commands overlap");

endmodule

@@ hdl/graphics_command_word_deframer.sv @@
// channel   dir  handshake          payload
// in_ch     in   valid / ready      cmd_word[31:0]
// out_ch    out  valid / ready      opcode[5:0] word_index[5:0] data_word[31:0] last_word
//
// each input word is stored as it is accepted; a command of N words then drains
// with one store read and one output handshake per word
// the single-port read of the pending store sets the drain rate
// input is held off while a command drains; out_ch stalls hold the current word
// rst_n is synchronous; the pending count clears, store contents are not cleared
module graphics_command_word_deframer #(
  parameter int STORE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  gcwd_in_if.sink    in_ch,
  gcwd_out_if.source out_ch
);
  import gcwd_pkg::*;

  cmd_t    cmd;
  status_t st;

  gcwd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  gcwd_dpath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_word    (in_ch.cmd_word),
    .opcode     (out_ch.opcode),
    .word_index (out_ch.word_index),
    .data_word  (out_ch.data_word),
    .last_word  (out_ch.last_word)
  );

endmodule
